// ----- rtl/btc_pkg.sv -----
// ----------------------------------------------------------------------------
// btc_pkg: shared types and constants of the block transposition cipher
// Register indexes, reset values, descriptor types and the key check.
// ----------------------------------------------------------------------------
package btc_pkg;

    // block geometry
    localparam int MAX_KEY_LEN = 10;
    localparam int LEN_W       = 4;
    localparam int DIGIT_W     = 4;
    localparam int KEY_W       = MAX_KEY_LEN * DIGIT_W;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = KEY_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_DIGITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR   = 2'd2;

    // register reset values
    localparam logic [LEN_W-1:0]  RST_KEY_LENGTH = 4'd10;
    localparam logic [KEY_W-1:0]  RST_KEY_DIGITS = 40'h98_7654_3210;
    localparam logic [BYTE_W-1:0] RST_PAD_CHAR   = 8'd33;

    // one finished block (or one error word) handed from front to back
    typedef struct packed {
        logic             err;
        logic             last;
        logic             bank;
        logic [LEN_W-1:0] count;
    } t_desc;

    // back tells front that a bank may be refilled
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    // key must be a permutation of 0..len-1
    function automatic logic key_ok(input logic [LEN_W-1:0] len,
                                    input logic [KEY_W-1:0] dig);
        logic               ok;
        logic [DIGIT_W-1:0] a;
        ok = (len != '0) && (len <= LEN_W'(MAX_KEY_LEN));
        for (int i = 0; i < MAX_KEY_LEN; i++) begin
            a = dig[DIGIT_W*i +: DIGIT_W];
            if (LEN_W'(i) < len) begin
                if (a >= len) begin
                    ok = 1'b0;
                end
                for (int k = 0; k < i; k++) begin
                    if (dig[DIGIT_W*k +: DIGIT_W] == a) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

// ----- rtl/btc_queue.sv -----
// ----------------------------------------------------------------------------
// btc_queue: two-entry descriptor queue
// Decouples the collecting front from the emitting back.
// ----------------------------------------------------------------------------
module btc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  btc_pkg::t_desc i_desc,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output btc_pkg::t_desc o_desc
);

    btc_pkg::t_desc r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_desc  = r_mem[r_rp];

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/btc_front.sv -----
// ----------------------------------------------------------------------------
// btc_front: input side of the transposition cipher
// Collects bytes into one of two block banks and queues finished blocks and key errors.
// ----------------------------------------------------------------------------
module btc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [btc_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_message_end,
    input  logic [btc_pkg::LEN_W-1:0]        i_key_length,
    input  logic                             i_key_ok,
    input  logic                             i_q_full,
    output logic                             o_push,
    output btc_pkg::t_desc                   o_desc,
    input  btc_pkg::t_release                i_release,
    input  logic                             i_rd_bank,
    input  logic [btc_pkg::LEN_W-1:0]        i_rd_idx,
    output logic [btc_pkg::BYTE_W-1:0]       o_rd_data
);

    logic [btc_pkg::BYTE_W-1:0] r_store [2][btc_pkg::MAX_KEY_LEN];
    logic [btc_pkg::LEN_W-1:0]  r_fill;
    logic                       r_wbank;
    logic [1:0]                 r_busy;

    logic                       accept;
    logic [btc_pkg::LEN_W-1:0]  eff_fill;
    logic [btc_pkg::LEN_W-1:0]  cnt;
    logic                       blk_done;
    logic [btc_pkg::LEN_W-1:0]  n_fill;
    logic [1:0]                 n_busy;

    // hold off while the queue is full or the fill bank is still being sent
    assign o_in_stall = i_q_full || (i_key_ok && r_busy[r_wbank]);
    assign accept     = i_in_valid && !o_in_stall;

    // a partial block no shorter than a shrunk key is dropped
    assign eff_fill = (r_fill >= i_key_length) ? '0 : r_fill;
    assign cnt      = eff_fill + 4'd1;
    assign blk_done = (cnt == i_key_length) || i_message_end;

    // queue descriptor, next fill count and bank ownership
    always_comb begin
        o_push       = accept && (!i_key_ok || blk_done);
        o_desc.err   = !i_key_ok;
        o_desc.last  = i_message_end;
        o_desc.bank  = r_wbank;
        o_desc.count = cnt;
        n_fill       = r_fill;
        if (accept) begin
            n_fill = (!i_key_ok || blk_done) ? '0 : cnt;
        end
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push && i_key_ok) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    // fill count, bank select and bank ownership
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_wbank <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_fill <= n_fill;
            r_busy <= n_busy;
            if (o_push && i_key_ok) begin
                r_wbank <= ~r_wbank;
            end
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (accept && i_key_ok) begin
            r_store[r_wbank][eff_fill] <= i_data_byte;
        end
    end

    assign o_rd_data = r_store[i_rd_bank][i_rd_idx];

endmodule

// ----- rtl/btc_back.sv -----
// ----------------------------------------------------------------------------
// btc_back: output side of the transposition cipher
// Walks the key over a queued block and sends one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module btc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [btc_pkg::LEN_W-1:0]        i_key_length,
    input  logic [btc_pkg::KEY_W-1:0]        i_key_digits,
    input  logic [btc_pkg::BYTE_W-1:0]       i_pad_char,
    input  logic                             i_q_valid,
    input  btc_pkg::t_desc                   i_q_desc,
    output logic                             o_pop,
    output btc_pkg::t_release                o_release,
    output logic                             o_rd_bank,
    output logic [btc_pkg::LEN_W-1:0]        o_rd_idx,
    input  logic [btc_pkg::BYTE_W-1:0]       i_rd_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [btc_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_block_last,
    output logic                             o_message_last,
    output logic                             o_is_padding,
    output logic                             o_key_error
);

    logic                       r_active;
    btc_pkg::t_desc             r_desc;
    logic [btc_pkg::LEN_W-1:0]  r_pos;
    logic                       r_out_valid;
    logic [btc_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_block_last;
    logic                       r_message_last;
    logic                       r_is_padding;
    logic                       r_key_error;

    logic                       out_ready;
    logic                       fire;
    logic                       pos_end;
    logic                       blk_end;
    logic [btc_pkg::LEN_W-1:0]  src;
    logic                       pad;

    // output register frees up when empty or taken
    assign out_ready = !r_out_valid || !i_out_stall;
    assign fire      = r_active && out_ready;
    assign pos_end   = (r_pos == i_key_length - 4'd1);
    assign blk_end   = fire && (r_desc.err || pos_end);
    assign o_pop     = i_q_valid && (!r_active || blk_end);

    // source position from the key, pad beyond the real bytes
    assign src       = i_key_digits[{r_pos, 2'b00} +: btc_pkg::DIGIT_W];
    assign pad       = (src >= r_desc.count);
    assign o_rd_bank = r_desc.bank;
    assign o_rd_idx  = src;

    assign o_release.valid = blk_end && !r_desc.err;
    assign o_release.bank  = r_desc.bank;

    // block walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_pos    <= '0;
            end else if (blk_end) begin
                r_active <= 1'b0;
            end else if (fire) begin
                r_pos <= r_pos + 4'd1;
            end
        end
    end

    // descriptor of the block in flight
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_desc;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (r_desc.err) begin
                r_out_byte     <= '0;
                r_block_last   <= 1'b0;
                r_message_last <= r_desc.last;
                r_is_padding   <= 1'b0;
                r_key_error    <= 1'b1;
            end else begin
                r_out_byte     <= pad ? i_pad_char : i_rd_data;
                r_block_last   <= pos_end;
                r_message_last <= pos_end && r_desc.last;
                r_is_padding   <= pad;
                r_key_error    <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_block_last   = r_block_last;
    assign o_message_last = r_message_last;
    assign o_is_padding   = r_is_padding;
    assign o_key_error    = r_key_error;

endmodule

// ----- rtl/block_transposition_cipher_core.sv -----
// The core takes one plaintext word per cycle unless it stalls and, for every
// full block or message end, sends key_length ciphertext words, one per cycle
// while the output is not stalled, permuted by the key; a final partial block
// is filled up with pad_char. An input that arrives while the key is not a
// permutation of 0..key_length-1 gives one error word and no block. Two block
// banks let the next block fill while the previous one drains; a bank is freed
// only at the edge that sends its last word. The back end sends one word per
// key position of a block (one word per error), and input stalls when
// both banks are waiting to be sent or the two-entry block queue is full.
// Short final blocks cost key_length output words for fewer input words.
// With the back end idle, the word that closes a block is pushed into the
// block queue, popped into the block walker and its first result is then
// registered in the output word register.
// ----------------------------------------------------------------------------
// block_transposition_cipher_core: top level of the transposition cipher
// Configuration registers, key check, front, block queue and back.
// ----------------------------------------------------------------------------
module block_transposition_cipher_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [btc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [btc_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_message_end,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [btc_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_block_last,
    output logic                              o_message_last,
    output logic                              o_is_padding,
    output logic                              o_key_error
);

    logic [btc_pkg::LEN_W-1:0]  r_key_length;
    logic [btc_pkg::KEY_W-1:0]  r_key_digits;
    logic [btc_pkg::BYTE_W-1:0] r_pad_char;

    logic                       key_ok;
    logic                       q_full;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_valid;
    btc_pkg::t_desc             push_desc;
    btc_pkg::t_desc             q_desc;
    btc_pkg::t_release          release_info;
    logic                       rd_bank;
    logic [btc_pkg::LEN_W-1:0]  rd_idx;
    logic [btc_pkg::BYTE_W-1:0] rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= btc_pkg::RST_KEY_LENGTH;
            r_key_digits <= btc_pkg::RST_KEY_DIGITS;
            r_pad_char   <= btc_pkg::RST_PAD_CHAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                btc_pkg::REG_KEY_LENGTH: r_key_length <= i_cfg_data[btc_pkg::LEN_W-1:0];
                btc_pkg::REG_KEY_DIGITS: r_key_digits <= i_cfg_data[btc_pkg::KEY_W-1:0];
                btc_pkg::REG_PAD_CHAR:   r_pad_char   <= i_cfg_data[btc_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // key permutation check
    assign key_ok = btc_pkg::key_ok(r_key_length, r_key_digits);

    btc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .i_key_length  (r_key_length),
        .i_key_ok      (key_ok),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_desc        (push_desc),
        .i_release     (release_info),
        .i_rd_bank     (rd_bank),
        .i_rd_idx      (rd_idx),
        .o_rd_data     (rd_data)
    );

    btc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    btc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_length   (r_key_length),
        .i_key_digits   (r_key_digits),
        .i_pad_char     (r_pad_char),
        .i_q_valid      (q_valid),
        .i_q_desc       (q_desc),
        .o_pop          (q_pop),
        .o_release      (release_info),
        .o_rd_bank      (rd_bank),
        .o_rd_idx       (rd_idx),
        .i_rd_data      (rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_block_last   (o_block_last),
        .o_message_last (o_message_last),
        .o_is_padding   (o_is_padding),
        .o_key_error    (o_key_error)
    );

endmodule

// ----- tb/tb_block_transposition_cipher_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_transposition_cipher_core: self-checking bench of the cipher core
// Plaintext words go in through a gap-inserting driver. A predictor updated
// at every accepted word queues the expected ciphertext words, and a monitor
// with random output stalls compares each one field by field. Phases switch
// key length, key and pad byte while the core is idle. They cover valid
// permutations, broken keys, cut-off messages and a shrunk key length.
// ----------------------------------------------------------------------------
module tb_block_transposition_cipher_core;

    localparam int MAX_KEY_LEN = btc_pkg::MAX_KEY_LEN;
    localparam int LEN_W       = btc_pkg::LEN_W;
    localparam int DIGIT_W     = btc_pkg::DIGIT_W;
    localparam int KEY_W       = btc_pkg::KEY_W;
    localparam int BYTE_W      = btc_pkg::BYTE_W;
    localparam int CFG_IDX_W   = btc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = btc_pkg::CFG_DATA_W;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_WORDS = 480;
    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] pt_byte;
        logic              msg_end;
    } t_plain_word;

    typedef struct packed {
        logic [BYTE_W-1:0] ct_byte;
        logic              blk_last;
        logic              msg_last;
        logic              pad;
        logic              err;
    } t_cipher_word;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  message_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  block_last;
    logic                  message_last;
    logic                  is_padding;
    logic                  key_error;

    block_transposition_cipher_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_message_end  (message_end),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_block_last   (block_last),
        .o_message_last (message_last),
        .o_is_padding   (is_padding),
        .o_key_error    (key_error)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_plain_word  plain_q[$];
    t_cipher_word cipher_q[$];

    // predictor copy of the registers and block state
    logic [LEN_W-1:0]  key_len  = btc_pkg::RST_KEY_LENGTH;
    logic [KEY_W-1:0]  key_dig  = btc_pkg::RST_KEY_DIGITS;
    logic [BYTE_W-1:0] pad_byte = btc_pkg::RST_PAD_CHAR;
    logic [BYTE_W-1:0] blk_bytes [MAX_KEY_LEN];
    logic              blk_pads  [MAX_KEY_LEN];
    int unsigned       fill_cnt = 0;

    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned idle_left = 0;
    int unsigned stall_left = 0;
    bit          no_idle = 1'b0;

    initial begin
        foreach (blk_pads[i]) begin
            blk_pads[i] = 1'b0;
            blk_bytes[i] = '0;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // key must list every block position below key_len exactly once
    function automatic bit key_is_perm();
        bit [15:0]        seen;
        logic [DIGIT_W-1:0] d;
        if (key_len == 0 || key_len > MAX_KEY_LEN) return 1'b0;
        seen = '0;
        for (int j = 0; j < key_len; j++) begin
            d = key_dig[DIGIT_W*j +: DIGIT_W];
            if (d >= key_len || seen[d]) return 1'b0;
            seen[d] = 1'b1;
        end
        return 1'b1;
    endfunction

    // random permutation of 0..len-1, junk in the unused entries
    function automatic logic [KEY_W-1:0] perm_key(input int unsigned len);
        logic [DIGIT_W-1:0] p [MAX_KEY_LEN];
        logic [DIGIT_W-1:0] t;
        logic [KEY_W-1:0]   k;
        int unsigned        s;
        for (int i = 0; i < MAX_KEY_LEN; i++) begin
            p[i] = (i < len) ? DIGIT_W'(i) : DIGIT_W'($urandom_range(0, 15));
        end
        for (int i = int'(len) - 1; i > 0; i--) begin
            s = $urandom_range(0, i);
            t = p[i];
            p[i] = p[s];
            p[s] = t;
        end
        for (int i = 0; i < MAX_KEY_LEN; i++) begin
            k[DIGIT_W*i +: DIGIT_W] = p[i];
        end
        return k;
    endfunction

    // update block state with one plaintext word, queue the ciphertext it releases
    task automatic encipher_word(input logic [BYTE_W-1:0] b, input logic fin);
        t_cipher_word       w;
        logic [DIGIT_W-1:0] src;
        if (!key_is_perm()) begin
            fill_cnt = 0;
            foreach (blk_pads[i]) blk_pads[i] = 1'b0;
            w = '{ct_byte: '0, blk_last: 1'b0, msg_last: fin, pad: 1'b0, err: 1'b1};
            cipher_q.push_back(w);
        end else begin
            // stale partial block after a shorter key length
            if (fill_cnt >= key_len) fill_cnt = 0;
            blk_bytes[fill_cnt] = b;
            blk_pads[fill_cnt] = 1'b0;
            fill_cnt++;
            if (fill_cnt >= key_len || fin) begin
                for (int j = fill_cnt; j < key_len; j++) begin
                    blk_bytes[j] = pad_byte;
                    blk_pads[j] = 1'b1;
                end
                for (int j = 0; j < key_len; j++) begin
                    src = key_dig[DIGIT_W*j +: DIGIT_W];
                    w.ct_byte  = blk_bytes[src];
                    w.blk_last = (j + 1 == key_len);
                    w.msg_last = (j + 1 == key_len) && fin;
                    w.pad      = blk_pads[src];
                    w.err      = 1'b0;
                    cipher_q.push_back(w);
                end
                fill_cnt = 0;
                foreach (blk_pads[i]) blk_pads[i] = 1'b0;
            end
        end
    endtask

    // input driver
    always @(posedge clk) begin
        t_plain_word w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) encipher_word(data_byte, message_end);
            // a stalled word holds still
            if (!(in_valid && in_stall)) begin
                if (idle_left != 0) begin
                    in_valid <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (plain_q.size() != 0) begin
                    w = plain_q.pop_front();
                    data_byte <= w.pt_byte;
                    message_end <= w.msg_end;
                    in_valid <= 1'b1;
                    idle_left <= no_idle ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // output monitor and stall generator
    always @(posedge clk) begin
        t_cipher_word w;
        int unsigned  n;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (cipher_q.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none, got byte %0h err %0b",
                             $time, out_byte, key_error);
                    mismatch_cnt++;
                end else begin
                    w = cipher_q.pop_front();
                    check_field("out_byte", w.ct_byte, out_byte);
                    check_field("block_last", BYTE_W'(w.blk_last), BYTE_W'(block_last));
                    check_field("message_last", BYTE_W'(w.msg_last), BYTE_W'(message_last));
                    check_field("is_padding", BYTE_W'(w.pad), BYTE_W'(is_padding));
                    check_field("key_error", BYTE_W'(w.err), BYTE_W'(key_error));
                end
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!no_idle && $urandom_range(0, 99) < 30) begin
                n = pick_gap();
                out_stall <= (n != 0);
                stall_left <= (n != 0) ? n - 1 : 0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("block_transposition_cipher_core: mismatch");
            $finish;
        end
    end

    // wait until the core has nothing left to send, plus a margin
    task automatic settle();
        while (plain_q.size() != 0 || in_valid || cipher_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            btc_pkg::REG_KEY_LENGTH: key_len = val[LEN_W-1:0];
            btc_pkg::REG_KEY_DIGITS: key_dig = val;
            btc_pkg::REG_PAD_CHAR:   pad_byte = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send(input logic [BYTE_W-1:0] b, input logic fin);
        plain_q.push_back('{pt_byte: b, msg_end: fin});
    endtask

    // stimulus
    initial begin
        int unsigned rnd_words;
        int unsigned len;
        int unsigned nmsg;
        int unsigned nb;
        int unsigned r;
        int unsigned a;
        int unsigned c;
        bit          good;
        bit          cut;
        logic [KEY_W-1:0] key;

        rnd_words = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: full identity block with extreme bytes, then a padded tail
        send(8'h00, 1'b0);
        send(8'hff, 1'b0);
        for (int i = 0; i < 8; i++) send(BYTE_W'(1 << i), 1'b0);
        send(8'h55, 1'b0);
        send(8'haa, 1'b1);
        settle();

        // one-byte blocks, unused key entries all ones, zero pad
        write_reg(btc_pkg::REG_KEY_LENGTH, KEY_W'(1));
        write_reg(btc_pkg::REG_KEY_DIGITS, 40'hff_ffff_fff0);
        write_reg(btc_pkg::REG_PAD_CHAR, '0);
        send(8'h7f, 1'b0);
        send(8'h80, 1'b1);
        settle();

        // reversed ten-byte key, pad all ones, short message
        write_reg(btc_pkg::REG_KEY_LENGTH, KEY_W'(MAX_KEY_LEN));
        write_reg(btc_pkg::REG_KEY_DIGITS, 40'h01_2345_6789);
        write_reg(btc_pkg::REG_PAD_CHAR, KEY_W'(8'hff));
        send(8'h3c, 1'b0);
        send(8'hc3, 1'b1);
        settle();

        // key length shrunk below a held partial block
        for (int i = 0; i < 4; i++) send(BYTE_W'($urandom_range(0, 255)), 1'b0);
        settle();
        write_reg(btc_pkg::REG_KEY_LENGTH, KEY_W'(3));
        write_reg(btc_pkg::REG_KEY_DIGITS, 40'hff_ffff_f021);
        write_reg(REG_UNUSED, '1);
        for (int i = 0; i < 3; i++) send(BYTE_W'($urandom_range(0, 255)), 1'b0);
        settle();

        // broken keys: zero length, too long, entry out of range, repeated entry
        write_reg(btc_pkg::REG_KEY_LENGTH, '0);
        send(8'h11, 1'b1);
        settle();
        write_reg(btc_pkg::REG_KEY_LENGTH, KEY_W'(15));
        send(8'h22, 1'b0);
        settle();
        write_reg(btc_pkg::REG_KEY_LENGTH, KEY_W'(4));
        write_reg(btc_pkg::REG_KEY_DIGITS, 40'h00_0000_4210);
        send(8'h33, 1'b1);
        settle();
        write_reg(btc_pkg::REG_KEY_DIGITS, 40'h00_0000_0113);
        send(8'h44, 1'b0);

        // random phases, each under its own key
        while (rnd_words < RANDOM_WORDS) begin
            settle();
            no_idle = 1'b0;
            good = ($urandom_range(0, 99) < 82);
            if (good) begin
                len = $urandom_range(1, MAX_KEY_LEN);
                key = perm_key(len);
            end else begin
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    len = $urandom_range(0, 1) ? 0 : $urandom_range(11, 15);
                    key = {BYTE_W'($urandom_range(0, 255)), 32'($urandom)};
                end else if (r == 1) begin
                    len = $urandom_range(1, MAX_KEY_LEN);
                    key = perm_key(len);
                    a = $urandom_range(0, len - 1);
                    key[DIGIT_W*a +: DIGIT_W] = DIGIT_W'($urandom_range(len, 15));
                end else begin
                    len = $urandom_range(2, MAX_KEY_LEN);
                    key = perm_key(len);
                    a = $urandom_range(0, len - 1);
                    c = (a + $urandom_range(1, len - 1)) % len;
                    key[DIGIT_W*a +: DIGIT_W] = key[DIGIT_W*c +: DIGIT_W];
                end
            end
            write_reg(btc_pkg::REG_KEY_LENGTH, KEY_W'(len));
            write_reg(btc_pkg::REG_KEY_DIGITS, key);
            if ($urandom_range(0, 9) < 7) begin
                write_reg(btc_pkg::REG_PAD_CHAR, KEY_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(REG_UNUSED, {BYTE_W'($urandom_range(0, 255)), 32'($urandom)});
            end
            no_idle = ($urandom_range(0, 3) == 0);

            if (good) begin
                // whole messages with random content, the last one now and then cut off
                nmsg = $urandom_range(2, 6);
                for (int m = 0; m < nmsg; m++) begin
                    r = $urandom_range(0, 99);
                    if (r < 70) nb = $urandom_range(1, 2 * len);
                    else if (r < 90) nb = $urandom_range(2 * len, 4 * len);
                    else nb = $urandom_range(1, 40);
                    cut = (m == nmsg - 1) && ($urandom_range(0, 9) == 0);
                    for (int i = 0; i < nb; i++) begin
                        send(BYTE_W'($urandom_range(0, 255)), (i == nb - 1) && !cut);
                    end
                    rnd_words += nb;
                end
            end else begin
                nb = $urandom_range(3, 10);
                for (int i = 0; i < nb; i++) begin
                    send(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                rnd_words += nb;
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("block_transposition_cipher_core: match");
        end else begin
            $display("block_transposition_cipher_core: mismatch");
        end
        $finish;
    end

endmodule
